[hdl/sqh_pkg.sv]
// shared types, constants and helper functions of the substitution quality histogram
package sqh_pkg;

  localparam int QUALITY_LEVELS = 64;
  localparam int MAX_READ_LEN   = 1024;

  localparam int TABLE_ROWS = 16;
  localparam int TBL_DEPTH  = TABLE_ROWS * QUALITY_LEVELS;
  localparam int TBL_AW     = $clog2(TBL_DEPTH);
  localparam int BUF_AW     = $clog2(MAX_READ_LEN);
  localparam int CNT_W      = $clog2(MAX_READ_LEN + 1);

  localparam int BASE_W  = 2;
  localparam int QUAL_W  = 6;
  localparam int ROW_W   = 2 * BASE_W;
  localparam int ENTRY_W = ROW_W + QUAL_W;
  localparam int CL_W    = 16;
  localparam int RLEN_W  = 11;
  localparam int MM_W    = 11;
  localparam int COUNT_W = 32;
  localparam int LIM_W   = 17;
  localparam int PROD_W  = LIM_W + RLEN_W;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [MM_W-1:0]    MM_MAX    = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_LIMIT = 2'd2;

  localparam logic ACT_ACCUM    = 1'b0;
  localparam logic ACT_READOUT  = 1'b1;
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  typedef struct packed {
    logic              action;
    logic [BASE_W-1:0] true_base;
    logic [BASE_W-1:0] read_base;
    logic [QUAL_W-1:0] quality;
    logic [CL_W-1:0]   cluster_index;
    logic [RLEN_W-1:0] read_length;
    logic              last_of_read;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic               read_kept;
    logic [MM_W-1:0]    mismatches;
    logic [COUNT_W-1:0] count_value;
  } out_item_t;

  // quality column that has a place in the table
  function automatic logic q_valid(input logic [QUAL_W-1:0] q);
    q_valid = (int'(q) < QUALITY_LEVELS);
  endfunction

  // table address of row and quality column
  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [ROW_W-1:0] row,
                                                 input logic [QUAL_W-1:0] q);
    tbl_addr = TBL_AW'(TBL_AW'(row) * TBL_AW'(QUALITY_LEVELS) + TBL_AW'(q));
  endfunction

endpackage

[hdl/sqh_if.sv]
// valid/ready channel interfaces for input items and result items
interface sqh_in_if;
  logic             valid;
  logic             ready;
  sqh_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sqh_out_if;
  logic              valid;
  logic              ready;
  sqh_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/sqh_ram.sv]
// generic simple dual port ram with registered read
module sqh_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/substitution_quality_histogram_top.sv]
// top level of the substitution quality histogram
// usage: in_i carries one aligned base per transfer (action accumulate) or a
//   count readout request (action readout, row = true_base*4 + read_base,
//   column = quality); out_o carries one verdict per last base and one count
//   per readout; cfg_we_i/cfg_idx_i/cfg_wdata_i write the three registers; the
//   user must do so only while the block is idle; the block does not enforce it
// how items pass through:
//   a non-last base is buffered in the read buffer ram and the block stays idle
//   a readout does one table ram read; its count goes to the output register
//   a last base passes buffer, multiply and compare; a kept read then replays
//   its n buffered bases through the count table with a two stage pipelined
//   read-modify-write that takes a new base before the last one is written
// reset: control and config registers take their reset values and a clearing
//   pass zeroes all 16 * QUALITY_LEVELS table entries with in_i.ready low;
//   config writes are taken during the pass
// stall: one output register holds a result; while it is full and not
//   taken, in_i.ready drops and the block waits
module substitution_quality_histogram_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  sqh_in_if.sink                               in_i,
  sqh_out_if.source                            out_o,
  input  logic                                 cfg_we_i,
  input  logic [sqh_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [sqh_pkg::CFG_W-1:0]            cfg_wdata_i
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_CHECK  = 3'd4;
  localparam logic [2:0] ST_REPLAY = 3'd5;

  // configuration registers
  logic [sqh_pkg::CL_W-1:0]  cl_cnt_q;
  logic                      filt_q;
  logic [sqh_pkg::LIM_W-1:0] lim_q;

  // control state
  logic [2:0]                  state_q, state_d;
  logic [sqh_pkg::TBL_AW-1:0]  clr_idx_q, clr_idx_d;
  logic [sqh_pkg::CNT_W-1:0]   buf_cnt_q, buf_cnt_d;
  logic [sqh_pkg::MM_W-1:0]    mm_q, mm_d;
  logic [sqh_pkg::CNT_W-1:0]   rp_idx_q, rp_idx_d;
  logic                        s1_vld_q, s1_vld_d;
  logic                        s2_vld_q, s2_vld_d;
  logic                        wr_vld_q, wr_vld_d;
  logic                        out_vld_q, out_vld_d;

  // payload registers
  logic [sqh_pkg::TBL_AW-1:0]  s2_addr_q, s2_addr_d;
  logic [sqh_pkg::TBL_AW-1:0]  wr_addr_q, wr_addr_d;
  logic [sqh_pkg::COUNT_W-1:0] wr_data_q, wr_data_d;
  logic [sqh_pkg::PROD_W-1:0]  prod_q, prod_d;
  logic [sqh_pkg::RLEN_W-1:0]  rlen_q, rlen_d;
  logic                        kept_pre_q, kept_pre_d;
  logic                        rd_zero_q, rd_zero_d;
  sqh_pkg::out_item_t          out_q, out_d;

  // ram ports
  logic                         buf_we;
  logic [sqh_pkg::BUF_AW-1:0]   buf_waddr;
  logic [sqh_pkg::ENTRY_W-1:0]  buf_wdata;
  logic [sqh_pkg::ENTRY_W-1:0]  buf_rdata;
  logic                         tbl_we;
  logic [sqh_pkg::TBL_AW-1:0]   tbl_waddr;
  logic [sqh_pkg::COUNT_W-1:0]  tbl_wdata;
  logic [sqh_pkg::TBL_AW-1:0]   tbl_raddr;
  logic [sqh_pkg::COUNT_W-1:0]  tbl_rdata;

  logic                         in_ready;
  logic                         in_xfer;
  logic                         issue;
  logic                         rp_done;
  logic [sqh_pkg::ROW_W-1:0]    s1_row;
  logic [sqh_pkg::QUAL_W-1:0]   s1_qual;
  logic [sqh_pkg::COUNT_W-1:0]  cnt_base;
  logic [sqh_pkg::COUNT_W-1:0]  cnt_inc;
  logic [sqh_pkg::PROD_W-1:0]   lhs;
  logic                         kept;
  logic [sqh_pkg::ROW_W-1:0]    in_row;

  // one result slot; accept only when it is free or emptied in this cycle
  assign in_ready = (state_q == ST_IDLE) && (!out_vld_q || out_o.ready);
  assign in_xfer  = in_i.valid && in_ready;
  assign in_row   = {in_i.data.true_base, in_i.data.read_base};

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // read buffer: written with up to MAX_READ_LEN bases, read in order in replay
  assign buf_we    = in_xfer && (in_i.data.action == sqh_pkg::ACT_ACCUM) &&
                     (buf_cnt_q < sqh_pkg::CNT_W'(sqh_pkg::MAX_READ_LEN));
  assign buf_waddr = buf_cnt_q[sqh_pkg::BUF_AW-1:0];
  assign buf_wdata = {in_row, in_i.data.quality};

  sqh_ram #(
    .Width (sqh_pkg::ENTRY_W),
    .Depth (sqh_pkg::MAX_READ_LEN)
  ) u_buf_ram (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .raddr_i (rp_idx_q[sqh_pkg::BUF_AW-1:0]),
    .rdata_o (buf_rdata)
  );

  // replay stage one: buffered entry arrives, table read issued
  assign issue   = (state_q == ST_REPLAY) && (rp_idx_q < buf_cnt_q);
  assign s1_row  = buf_rdata[sqh_pkg::ENTRY_W-1:sqh_pkg::QUAL_W];
  assign s1_qual = buf_rdata[sqh_pkg::QUAL_W-1:0];

  // readout address in idle, replay address otherwise
  assign tbl_raddr = (state_q == ST_IDLE) ? sqh_pkg::tbl_addr(in_row, in_i.data.quality)
                                          : sqh_pkg::tbl_addr(s1_row, s1_qual);

  // replay stage two: forward the write of the previous cycle to the same entry
  assign cnt_base = (wr_vld_q && (wr_addr_q == s2_addr_q)) ? wr_data_q : tbl_rdata;
  assign cnt_inc  = (cnt_base == sqh_pkg::COUNT_MAX) ? cnt_base
                                                      : cnt_base + sqh_pkg::COUNT_W'(1);

  assign tbl_we    = (state_q == ST_CLEAR) || s2_vld_q;
  assign tbl_waddr = (state_q == ST_CLEAR) ? clr_idx_q : s2_addr_q;
  assign tbl_wdata = (state_q == ST_CLEAR) ? '0 : cnt_inc;

  sqh_ram #(
    .Width (sqh_pkg::COUNT_W),
    .Depth (sqh_pkg::TBL_DEPTH)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // filter compare: mismatches * 65536 against limit * read length
  assign lhs     = sqh_pkg::PROD_W'({mm_q, 16'h0000});
  assign kept    = kept_pre_q && !(filt_q && (lhs > prod_q));
  assign rp_done = !issue && !s1_vld_q && !s2_vld_q;

  always_comb begin
    state_d    = state_q;
    clr_idx_d  = clr_idx_q;
    buf_cnt_d  = buf_cnt_q;
    mm_d       = mm_q;
    rp_idx_d   = rp_idx_q;
    s1_vld_d   = 1'b0;
    s2_vld_d   = s1_vld_q && sqh_pkg::q_valid(s1_qual);
    s2_addr_d  = sqh_pkg::tbl_addr(s1_row, s1_qual);
    wr_vld_d   = s2_vld_q;
    wr_addr_d  = s2_addr_q;
    wr_data_d  = cnt_inc;
    prod_d     = prod_q;
    rlen_d     = rlen_q;
    kept_pre_d = kept_pre_q;
    rd_zero_d  = rd_zero_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_o.ready;

    unique case (state_q)
      ST_CLEAR: begin
        clr_idx_d = clr_idx_q + sqh_pkg::TBL_AW'(1);
        if (clr_idx_q == sqh_pkg::TBL_AW'(sqh_pkg::TBL_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_i.data.action == sqh_pkg::ACT_READOUT) begin
            rd_zero_d = !sqh_pkg::q_valid(in_i.data.quality);
            state_d   = ST_READ;
          end else begin
            if (buf_we) begin
              buf_cnt_d = buf_cnt_q + sqh_pkg::CNT_W'(1);
              if ((in_i.data.true_base != in_i.data.read_base) &&
                  (mm_q != sqh_pkg::MM_MAX)) begin
                mm_d = mm_q + sqh_pkg::MM_W'(1);
              end
            end
            if (in_i.data.last_of_read) begin
              kept_pre_d = in_i.data.cluster_index < cl_cnt_q;
              rlen_d     = in_i.data.read_length;
              state_d    = ST_MUL;
            end
          end
        end
      end
      ST_READ: begin
        out_vld_d         = 1'b1;
        out_d.result_kind = sqh_pkg::KIND_READOUT;
        out_d.read_kept   = 1'b0;
        out_d.mismatches  = '0;
        out_d.count_value = rd_zero_q ? '0 : tbl_rdata;
        state_d           = ST_IDLE;
      end
      ST_MUL: begin
        prod_d  = sqh_pkg::PROD_W'(lim_q) * sqh_pkg::PROD_W'(rlen_q);
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        rp_idx_d = '0;
        if (kept) begin
          state_d = ST_REPLAY;
        end else begin
          out_vld_d         = 1'b1;
          out_d.result_kind = sqh_pkg::KIND_VERDICT;
          out_d.read_kept   = 1'b0;
          out_d.mismatches  = mm_q;
          out_d.count_value = '0;
          buf_cnt_d         = '0;
          mm_d              = '0;
          state_d           = ST_IDLE;
        end
      end
      ST_REPLAY: begin
        s1_vld_d = issue;
        if (issue) begin
          rp_idx_d = rp_idx_q + sqh_pkg::CNT_W'(1);
        end
        if (rp_done) begin
          out_vld_d         = 1'b1;
          out_d.result_kind = sqh_pkg::KIND_VERDICT;
          out_d.read_kept   = 1'b1;
          out_d.mismatches  = mm_q;
          out_d.count_value = '0;
          buf_cnt_d         = '0;
          mm_d              = '0;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_cnt_q <= '1;
      filt_q   <= 1'b0;
      lim_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sqh_pkg::CFG_CLUSTER_COUNT:  cl_cnt_q <= cfg_wdata_i[sqh_pkg::CL_W-1:0];
        sqh_pkg::CFG_FILTER_ENABLE:  filt_q   <= cfg_wdata_i[0];
        sqh_pkg::CFG_MISMATCH_LIMIT: lim_q    <= cfg_wdata_i[sqh_pkg::LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
      buf_cnt_q <= '0;
      mm_q      <= '0;
      rp_idx_q  <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      wr_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      buf_cnt_q <= buf_cnt_d;
      mm_q      <= mm_d;
      rp_idx_q  <= rp_idx_d;
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s2_vld_d;
      wr_vld_q  <= wr_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_addr_q  <= s2_addr_d;
    wr_addr_q  <= wr_addr_d;
    wr_data_q  <= wr_data_d;
    prod_q     <= prod_d;
    rlen_q     <= rlen_d;
    kept_pre_q <= kept_pre_d;
    rd_zero_q  <= rd_zero_d;
    out_q      <= out_d;
  end

endmodule

[hdl/sqh_checker.sv]
// port level checker of the substitution quality histogram, bound to the top level
module sqh_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_action_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_kind_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // clearing pass holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_i)
    else $error("input ready during table clearing");

  // readout keeps the block busy for its ram read
  a_readout_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_action_i == sqh_pkg::ACT_READOUT) |=> !in_ready_i)
    else $error("input ready while readout in flight");

  // readout result shows after its table ram read and the output register
  a_readout_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_action_i == sqh_pkg::ACT_READOUT) |->
      ##2 (out_valid_i && out_kind_i == sqh_pkg::KIND_READOUT))
    else $error("readout result missing");

  // a base that does not end a read gives no result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_action_i == sqh_pkg::ACT_ACCUM && !in_last_i) |=> !out_valid_i)
    else $error("result after non-last base");

  // a waiting result stays offered until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result withdrawn before transfer");

endmodule

bind substitution_quality_histogram_top sqh_checker u_sqh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.data.action),
  .in_last_i   (in_i.data.last_of_read),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.data.result_kind)
);
